// ----- hdl/s2d_pkg.sv -----
package s2d_pkg;

  localparam int VALUE_WIDTH = 32;

  // Decimal digits of 2^(VALUE_WIDTH-1): floor((W-1)*log10(2)) + 1.
  localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_WIDTH  = NUM_DIGITS * 4;
  localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic shift;
  } dabble_cmd_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    return CHAR_ZERO | {4'b0000, d};
  endfunction

endpackage

// ----- hdl/s2d_dabble.sv -----
module s2d_dabble (
  input  logic                                clk,
  input  s2d_pkg::dabble_cmd_t                cmd,
  input  logic [s2d_pkg::VALUE_WIDTH-1:0]     mag,
  output logic [3:0]                          top_digit
);

  logic [s2d_pkg::VALUE_WIDTH-1:0] bin;
  logic [s2d_pkg::BCD_WIDTH-1:0]   bcd;
  logic [s2d_pkg::BCD_WIDTH-1:0]   bcd_adj;

  // Add three to every digit of five or more before the shift.
  always_comb begin
    for (int i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bin <= mag;
      bcd <= '0;
    end else if (cmd.step) begin
      bcd <= {bcd_adj[s2d_pkg::BCD_WIDTH-2:0], bin[s2d_pkg::VALUE_WIDTH-1]};
      bin <= {bin[s2d_pkg::VALUE_WIDTH-2:0], 1'b0};
    end else if (cmd.shift) begin
      // During output the digits move up one place per character.
      bcd <= {bcd[s2d_pkg::BCD_WIDTH-5:0], 4'b0000};
    end
  end

  assign top_digit = bcd[s2d_pkg::BCD_WIDTH-1 -: 4];

endmodule

// ----- hdl/signed_binary_to_decimal_ascii.sv -----
// Signed binary to decimal ASCII converter.
//
// The input channel (in_valid, in_stall, value) takes one two's complement
// integer. The output channel (out_valid, out_stall, character, last) gives
// its decimal text one ASCII character per item, most significant first:
// a '-' for a negative value, then the digits without leading zeros. Zero
// gives a single '0'. The final character of a number carries last.
//
// Conversion is a double dabble that shifts the VALUE_WIDTH bits of the
// magnitude in one bit per cycle through a shared add-three and shift unit.
// Leading zero digits are then dropped one per cycle, and the characters
// leave one per cycle while the output does not stall. in_stall is high
// from the accepting edge until the last character sits in the output
// register, so no new item is taken before then. A stall on the output
// holds the current character and pauses the sequencer in its sign and
// digit output states. Reset empties the output register and returns the
// sequencer to idle; no item is in flight after it.
module signed_binary_to_decimal_ascii (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [s2d_pkg::VALUE_WIDTH-1:0] value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [7:0]                          character,
  output logic                                last
);

  s2d_pkg::state_t state, state_next;
  s2d_pkg::dabble_cmd_t cmd;

  logic [s2d_pkg::BIT_CNT_W-1:0] bit_cnt;
  logic [s2d_pkg::DIG_CNT_W-1:0] dig_cnt;
  logic                          neg;
  logic [s2d_pkg::VALUE_WIDTH-1:0] mag;
  logic [3:0]                    top_digit;
  logic                          accept;
  logic                          out_free;
  logic                          out_load;
  logic [7:0]                    out_char;
  logic                          out_last;

  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign mag      = value[s2d_pkg::VALUE_WIDTH-1] ? (~value + 1'b1) : value;

  s2d_dabble u_dabble (
    .clk       (clk),
    .cmd       (cmd),
    .mag       (mag),
    .top_digit (top_digit)
  );

  always_comb begin
    state_next = state;
    case (state)
      s2d_pkg::ST_IDLE: begin
        if (in_valid) state_next = s2d_pkg::ST_CONV;
      end
      s2d_pkg::ST_CONV: begin
        if (bit_cnt == s2d_pkg::BIT_CNT_W'(s2d_pkg::VALUE_WIDTH - 1)) begin
          state_next = neg ? s2d_pkg::ST_SIGN : s2d_pkg::ST_SKIP;
        end
      end
      s2d_pkg::ST_SIGN: begin
        if (out_free) state_next = s2d_pkg::ST_SKIP;
      end
      s2d_pkg::ST_SKIP: begin
        if (top_digit != 4'd0 || dig_cnt == s2d_pkg::DIG_CNT_W'(1)) begin
          state_next = s2d_pkg::ST_EMIT;
        end
      end
      s2d_pkg::ST_EMIT: begin
        if (out_free && dig_cnt == s2d_pkg::DIG_CNT_W'(1)) state_next = s2d_pkg::ST_IDLE;
      end
      default: state_next = s2d_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    out_load = 1'b0;
    out_char = s2d_pkg::CHAR_MINUS;
    out_last = 1'b0;
    in_stall = 1'b1;
    case (state)
      s2d_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.load = in_valid;
      end
      s2d_pkg::ST_CONV: begin
        cmd.step = 1'b1;
      end
      s2d_pkg::ST_SIGN: begin
        out_load = out_free;
      end
      s2d_pkg::ST_SKIP: begin
        cmd.shift = (top_digit == 4'd0) && (dig_cnt != s2d_pkg::DIG_CNT_W'(1));
      end
      s2d_pkg::ST_EMIT: begin
        out_load  = out_free;
        out_char  = s2d_pkg::digit_char(top_digit);
        out_last  = (dig_cnt == s2d_pkg::DIG_CNT_W'(1));
        cmd.shift = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= s2d_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      neg     <= value[s2d_pkg::VALUE_WIDTH-1];
      bit_cnt <= '0;
      dig_cnt <= s2d_pkg::DIG_CNT_W'(s2d_pkg::NUM_DIGITS);
    end else begin
      if (cmd.step) bit_cnt <= bit_cnt + 1'b1;
      if (cmd.shift) dig_cnt <= dig_cnt - 1'b1;
    end
    if (out_load) begin
      character <= out_char;
      last      <= out_last;
    end
  end

  // The sequencer starts a conversion on every accepted item.
  a_accept_conv: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == s2d_pkg::ST_CONV)
    else $error("accepted item did not start a conversion");

  // Only the minus sign or a decimal digit ever leaves the block.
  a_char_legal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (character == s2d_pkg::CHAR_MINUS) ||
                  (character >= s2d_pkg::CHAR_ZERO && character <= 8'h39))
    else $error("illegal character on output");

  // When the block is ready again, a waiting character must be the final one.
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    (!in_stall && out_valid) |-> last)
    else $error("block idle while a number's text is unfinished");

  // A character is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_load |-> out_free)
    else $error("output register overwritten while stalled");

endmodule
